@@ rtl/brb_pkg.sv @@
// Shared types and codes for the circular byte FIFO.
package brb_pkg;

   typedef enum logic [2:0] {
      FUNC_ENQ_BEGIN = 3'd0,
      FUNC_ENQ_DATA  = 3'd1,
      FUNC_DEQUEUE   = 3'd2,
      FUNC_PEEK      = 3'd3,
      FUNC_CLEAR     = 3'd4
   } brb_func_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_REJECT = 2'd1,
      STAT_SHORT  = 2'd2
   } brb_status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EMIT = 1'b1
   } brb_state_type;

   // controller to datapath
   typedef struct packed {
      logic take_item;
      logic emit_byte;
      logic next_read;
   } brb_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slot_free;
      logic run_item;
      logic run_last;
   } brb_stat_type;

endpackage

@@ rtl/brb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/brb_ctrl.sv @@
// Controller: accepts items and sequences the byte runs of dequeue and peek.
module brb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  brb_pkg::brb_stat_type stat,
   output brb_pkg::brb_cmd_type  cmd
);
   import brb_pkg::*;

   brb_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && stat.slot_free && stat.run_item) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.slot_free && stat.run_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd.take_item = 1'b0;
      cmd.emit_byte = 1'b0;
      cmd.next_read = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = stat.slot_free;
            cmd.take_item = req_valid && stat.slot_free;
         end
         ST_EMIT: begin
            cmd.emit_byte = stat.slot_free;
            // fetch the following byte while this one goes out
            cmd.next_read = stat.slot_free && !stat.run_last;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/brb_dp.sv @@
// Datapath: pointers, counts, pending transfer, run counters and result register.
module brb_dp #(
   parameter int DEPTH        = 4096,
   parameter int MAX_TRANSFER = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  brb_pkg::brb_cmd_type     cmd,
   output brb_pkg::brb_stat_type    stat,
   input  logic [2:0]               req_func,
   input  logic [6:0]               req_length,
   input  logic [7:0]               req_data_in,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_data_out,
   output logic [1:0]               rsp_status,
   output logic [6:0]               rsp_byte_count,
   output logic [11:0]              rsp_used_count,
   output logic [11:0]              rsp_free_count,
   output logic                     rsp_last,
   output logic                     mem_wr_en,
   output logic [$clog2(DEPTH)-1:0] mem_wr_addr,
   output logic [7:0]               mem_wr_data,
   output logic                     mem_rd_en,
   output logic [$clog2(DEPTH)-1:0] mem_rd_addr,
   input  logic [7:0]               mem_rd_data
);
   import brb_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int SW = ((PW > 7) ? PW : 7) + 2;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   function automatic logic [11:0] free_of(input logic [PW-1:0] u);
      return 12'(SW'(DEPTH - 1) - SW'(u));
   endfunction

   logic [PW-1:0] rp_ff, rp_in, wp_ff, wp_in, used_ff, used_in;
   logic [PW-1:0] run_ptr_ff, run_ptr_in;
   logic [6:0]    pend_ff, pend_in, run_left_ff, run_left_in, run_len_ff, run_len_in;
   logic          acc_ff, acc_in, out_valid_ff, out_valid_in;
   logic [7:0]    data_ff, data_in;
   logic [1:0]    status_ff, status_in;
   logic [6:0]    count_ff, count_in;
   logic [11:0]   used_out_ff, used_out_in, free_out_ff, free_out_in;
   logic          last_ff, last_in;

   logic [SW-1:0] len_w, used_w, free_w, adv_w;
   brb_status_type one_status;
   logic [6:0]     one_count;
   logic           run_item, store_byte;

   assign len_w  = SW'(req_length);
   assign used_w = SW'(used_ff);
   assign free_w = SW'(DEPTH - 1) - used_w;
   assign adv_w  = (SW'(rp_ff) + len_w >= SW'(DEPTH)) ?
                   SW'(rp_ff) + len_w - SW'(DEPTH) : SW'(rp_ff) + len_w;

   // decode the item against the current state
   always_comb begin
      one_status = STAT_OK;
      one_count  = '0;
      run_item   = 1'b0;
      store_byte = 1'b0;
      rp_in      = rp_ff;
      wp_in      = wp_ff;
      used_in    = used_ff;
      pend_in    = pend_ff;
      acc_in     = acc_ff;
      case (req_func)
         FUNC_ENQ_BEGIN: begin
            if (len_w > SW'(MAX_TRANSFER) || len_w > free_w) begin
               one_status = STAT_REJECT;
               pend_in    = '0;
               acc_in     = 1'b0;
            end else begin
               one_count = req_length;
               pend_in   = req_length;
               acc_in    = (req_length != '0);
            end
         end
         FUNC_ENQ_DATA: begin
            if (acc_ff && pend_ff != '0 && free_w != '0) begin
               store_byte = 1'b1;
               one_count  = 7'd1;
               wp_in      = bump(wp_ff);
               used_in    = used_ff + PW'(1);
               pend_in    = pend_ff - 7'd1;
               if (pend_ff == 7'd1) begin
                  acc_in = 1'b0;
               end
            end else begin
               one_status = STAT_REJECT;
            end
         end
         FUNC_DEQUEUE, FUNC_PEEK: begin
            if (len_w > SW'(MAX_TRANSFER) ||
                (req_func == FUNC_DEQUEUE && len_w > used_w)) begin
               one_status = STAT_REJECT;
            end else if (len_w > used_w) begin
               one_status = STAT_SHORT;
               one_count  = (used_w > SW'(MAX_TRANSFER)) ? 7'(MAX_TRANSFER) : 7'(used_w);
            end else if (req_length != '0) begin
               run_item = 1'b1;
               if (req_func == FUNC_DEQUEUE) begin
                  rp_in   = PW'(adv_w);
                  used_in = used_ff - PW'(req_length);
               end
            end
         end
         FUNC_CLEAR: begin
            rp_in   = '0;
            wp_in   = '0;
            used_in = '0;
            pend_in = '0;
            acc_in  = 1'b0;
         end
         default: begin
            one_status = STAT_REJECT;
         end
      endcase
   end

   assign stat.slot_free = !out_valid_ff || rsp_ready;
   assign stat.run_item  = run_item;
   assign stat.run_last  = (run_left_ff == 7'd1);

   assign mem_wr_en   = cmd.take_item && store_byte;
   assign mem_wr_addr = wp_ff;
   assign mem_wr_data = req_data_in;
   assign mem_rd_en   = (cmd.take_item && run_item) || cmd.next_read;
   assign mem_rd_addr = cmd.take_item ? rp_ff : run_ptr_ff;

   // run counters and result register
   always_comb begin
      run_ptr_in   = run_ptr_ff;
      run_left_in  = run_left_ff;
      run_len_in   = run_len_ff;
      out_valid_in = out_valid_ff;
      data_in      = data_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      used_out_in  = used_out_ff;
      free_out_in  = free_out_ff;
      last_in      = last_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.take_item && run_item) begin
         run_ptr_in  = bump(rp_ff);
         run_left_in = req_length;
         run_len_in  = req_length;
      end else if (cmd.take_item) begin
         out_valid_in = 1'b1;
         data_in      = '0;
         status_in    = one_status;
         count_in     = one_count;
         used_out_in  = 12'(used_in);
         free_out_in  = free_of(used_in);
         last_in      = 1'b1;
      end
      if (cmd.emit_byte) begin
         out_valid_in = 1'b1;
         data_in      = mem_rd_data;
         status_in    = STAT_OK;
         count_in     = run_len_ff;
         used_out_in  = 12'(used_ff);
         free_out_in  = free_of(used_ff);
         last_in      = stat.run_last;
         run_left_in  = run_left_ff - 7'd1;
      end
      if (cmd.next_read) begin
         run_ptr_in = bump(run_ptr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff        <= '0;
         wp_ff        <= '0;
         used_ff      <= '0;
         pend_ff      <= '0;
         acc_ff       <= 1'b0;
         run_left_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.take_item) begin
            rp_ff   <= rp_in;
            wp_ff   <= wp_in;
            used_ff <= used_in;
            pend_ff <= pend_in;
            acc_ff  <= acc_in;
         end
         run_left_ff  <= run_left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ptr_ff  <= run_ptr_in;
      run_len_ff  <= run_len_in;
      data_ff     <= data_in;
      status_ff   <= status_in;
      count_ff    <= count_in;
      used_out_ff <= used_out_in;
      free_out_ff <= free_out_in;
      last_ff     <= last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_data_out   = data_ff;
   assign rsp_status     = status_ff;
   assign rsp_byte_count = count_ff;
   assign rsp_used_count = used_out_ff;
   assign rsp_free_count = free_out_ff;
   assign rsp_last       = last_ff;

endmodule

@@ rtl/byte_ring_buffer.sv @@
// Single-result items: result valid the cycle after accept, one per cycle
// while rsp_ready. Dequeue/peek run of n bytes: first byte via the registered
// buffer read and result register, then one byte per cycle while rsp_ready;
// no new item until the last byte. The buffer memory port sets the byte rate.
// Synchronous reset empties the buffer at once; storage itself is not cleared.
module byte_ring_buffer #(
   parameter int DEPTH        = 4096,
   parameter int MAX_TRANSFER = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [6:0]  req_length,
   input  logic [7:0]  req_data_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_out,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_byte_count,
   output logic [11:0] rsp_used_count,
   output logic [11:0] rsp_free_count,
   output logic        rsp_last
);
   import brb_pkg::*;

   localparam int PW = $clog2(DEPTH);

   brb_cmd_type   cmd;
   brb_stat_type  stat;
   logic          mem_wr_en, mem_rd_en;
   logic [PW-1:0] mem_wr_addr, mem_rd_addr;
   logic [7:0]    mem_wr_data, mem_rd_data;

   brb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   brb_dp #(
      .DEPTH        (DEPTH),
      .MAX_TRANSFER (MAX_TRANSFER)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_func       (req_func),
      .req_length     (req_length),
      .req_data_in    (req_data_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data_out   (rsp_data_out),
      .rsp_status     (rsp_status),
      .rsp_byte_count (rsp_byte_count),
      .rsp_used_count (rsp_used_count),
      .rsp_free_count (rsp_free_count),
      .rsp_last       (rsp_last),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   brb_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

@@ rtl/brb_checker.sv @@
// Port-level checks for the circular byte FIFO, bound to the top level.
module brb_checker #(
   parameter int DEPTH = 4096
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_data_out,
   input logic [1:0]  rsp_status,
   input logic [6:0]  rsp_byte_count,
   input logic [11:0] rsp_used_count,
   input logic [11:0] rsp_free_count,
   input logic        rsp_last
);
   import brb_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   a_counts_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 12'(rsp_used_count + rsp_free_count) == 12'(DEPTH - 1))
      else $error("used and free counts disagree");

   a_reject_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_REJECT |->
         rsp_byte_count == '0 && rsp_data_out == '0 && rsp_last)
      else $error("rejected result carries data");

   // a run streams without gaps and blocks new items until its last beat
   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside a byte run");

   a_run_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("item accepted during a byte run");

endmodule

bind byte_ring_buffer brb_checker #(.DEPTH(DEPTH)) u_brb_checker (.*);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the circular byte FIFO: directed and random traffic.
`timescale 1ns / 100ps

module testbench;
   import brb_pkg::*;

   localparam int RING_DEPTH   = 4096;
   localparam int MAX_XFER     = 64;
   localparam int RANDOM_ITEMS = 340;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      logic [2:0] func;
      logic [6:0] length;
      logic [7:0] data_in;
   } ring_req_type;

   typedef struct {
      logic [7:0]     data;
      brb_status_type status;
      logic [6:0]     count;
      logic [11:0]    used;
      logic [11:0]    free;
      logic           last;
   } ring_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_func = '0;
   logic [6:0]  req_length = '0;
   logic [7:0]  req_data_in = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_data_out;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_byte_count;
   logic [11:0] rsp_used_count;
   logic [11:0] rsp_free_count;
   logic        rsp_last;

   byte_ring_buffer #(
      .DEPTH        (RING_DEPTH),
      .MAX_TRANSFER (MAX_XFER)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_length     (req_length),
      .req_data_in    (req_data_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data_out   (rsp_data_out),
      .rsp_status     (rsp_status),
      .rsp_byte_count (rsp_byte_count),
      .rsp_used_count (rsp_used_count),
      .rsp_free_count (rsp_free_count),
      .rsp_last       (rsp_last)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Ring predictor
   // ---------------------------------------------------------------
   logic [7:0]    ring_mem [0:RING_DEPTH-1];
   logic [11:0]   rd_ptr;
   logic [11:0]   wr_ptr;
   logic [6:0]    pend_bytes;
   logic          pend_live;
   ring_beat_type awaited_beats [$];

   function automatic logic [11:0] ring_used();
      return 12'(wr_ptr - rd_ptr);
   endfunction

   // used and free reflect the state after the whole item
   function automatic void post_beat(logic [7:0] data, brb_status_type status,
                                     logic [6:0] count, logic last);
      ring_beat_type b;
      b.data   = data;
      b.status = status;
      b.count  = count;
      b.used   = ring_used();
      b.free   = 12'(RING_DEPTH - 1 - int'(ring_used()));
      b.last   = last;
      awaited_beats.push_back(b);
   endfunction

   function automatic void ring_apply(logic [2:0] func, logic [6:0] len, logic [7:0] din);
      int          used;
      int          freec;
      logic [11:0] p;
      used  = int'(ring_used());
      freec = RING_DEPTH - 1 - used;
      case (func)
         FUNC_ENQ_BEGIN: begin
            if (len > MAX_XFER || int'(len) > freec) begin
               pend_bytes = '0;
               pend_live  = 1'b0;
               post_beat('0, STAT_REJECT, '0, 1'b1);
            end else begin
               pend_bytes = len;
               pend_live  = (len != 0);
               post_beat('0, STAT_OK, len, 1'b1);
            end
         end
         FUNC_ENQ_DATA: begin
            if (pend_live && pend_bytes > 0 && freec > 0) begin
               ring_mem[wr_ptr] = din;
               wr_ptr = wr_ptr + 1'b1;
               pend_bytes = pend_bytes - 1'b1;
               if (pend_bytes == 0) pend_live = 1'b0;
               post_beat('0, STAT_OK, 7'd1, 1'b1);
            end else begin
               post_beat('0, STAT_REJECT, '0, 1'b1);
            end
         end
         FUNC_DEQUEUE, FUNC_PEEK: begin
            if (len > MAX_XFER || (func == FUNC_DEQUEUE && int'(len) > used)) begin
               post_beat('0, STAT_REJECT, '0, 1'b1);
            end else if (int'(len) > used) begin
               post_beat('0, STAT_SHORT, 7'((used > MAX_XFER) ? MAX_XFER : used), 1'b1);
            end else if (len == 0) begin
               post_beat('0, STAT_OK, '0, 1'b1);
            end else begin
               p = rd_ptr;
               if (func == FUNC_DEQUEUE) rd_ptr = rd_ptr + 12'(len);
               for (int i = 0; i < int'(len); i++) begin
                  post_beat(ring_mem[p], STAT_OK, len, i == int'(len) - 1);
                  p = p + 1'b1;
               end
            end
         end
         FUNC_CLEAR: begin
            rd_ptr     = '0;
            wr_ptr     = '0;
            pend_bytes = '0;
            pend_live  = 1'b0;
            post_beat('0, STAT_OK, '0, 1'b1);
         end
         default: post_beat('0, STAT_REJECT, '0, 1'b1);
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Stimulus plan, with a shadow fill level to steer it
   // ---------------------------------------------------------------
   ring_req_type req_backlog [$];
   int plan_used = 0;
   int plan_pend = 0;

   function automatic void add_item(logic [2:0] f, int len, logic [7:0] d);
      ring_req_type r;
      int freec;
      freec = RING_DEPTH - 1 - plan_used;
      case (f)
         FUNC_ENQ_BEGIN: plan_pend = (len <= MAX_XFER && len <= freec) ? len : 0;
         FUNC_ENQ_DATA: begin
            if (plan_pend > 0) begin
               plan_used++;
               plan_pend--;
            end
         end
         FUNC_DEQUEUE: if (len <= MAX_XFER && len <= plan_used) plan_used -= len;
         FUNC_CLEAR: begin
            plan_used = 0;
            plan_pend = 0;
         end
         default: ;
      endcase
      r.func    = f;
      r.length  = 7'(len);
      r.data_in = d;
      req_backlog.push_back(r);
   endfunction

   // begin of n bytes followed by only the first sent of them
   function automatic void add_transfer(int n, int sent);
      add_item(FUNC_ENQ_BEGIN, n, 8'($urandom));
      for (int i = 0; i < sent; i++) add_item(FUNC_ENQ_DATA, 0, 8'($urandom_range(0, 255)));
   endfunction

   // ---------------------------------------------------------------
   // Driver: bursts with random gaps
   // ---------------------------------------------------------------
   int           burst_left = 0;
   int           gap_left = 0;
   int           items_sent = 0;
   logic         req_taken;
   ring_req_type next_req;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
         rd_ptr     = '0;
         wr_ptr     = '0;
         pend_bytes = '0;
         pend_live  = 1'b0;
      end else begin
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            ring_apply(req_func, req_length, req_data_in);
            items_sent++;
         end
         if (!req_valid || req_taken) begin
            if (burst_left == 0 && gap_left == 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
            if (burst_left > 0 && req_backlog.size() > 0) begin
               next_req = req_backlog.pop_front();
               req_valid   <= 1'b1;
               req_func    <= next_req.func;
               req_length  <= next_req.length;
               req_data_in <= next_req.data_in;
               burst_left--;
            end else begin
               req_valid <= 1'b0;
               if (burst_left == 0 && gap_left > 0) gap_left--;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Receiver: stall modes, plus one long hold-off to back up the input
   // ---------------------------------------------------------------
   int rx_beats = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int stall_mode = 0;
   int mode_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) rx_beats++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && rx_beats >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(32, 256);
            end
            mode_left--;
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor and checker
   // ---------------------------------------------------------------
   int            failures = 0;
   int            beats_checked = 0;
   int            runs_closed = 0;
   ring_beat_type want;

   function automatic void check_field(string field, logic [11:0] exp_val, logic [11:0] act_val);
      if (exp_val !== act_val) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, field, exp_val, act_val);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_beats.size() == 0) begin
            failures++;
            $display("%0t: unexpected beat, expected none, actual data %0d status %0d",
                     $time, rsp_data_out, rsp_status);
         end else begin
            want = awaited_beats.pop_front();
            check_field("data_out",   12'(want.data),   12'(rsp_data_out));
            check_field("status",     12'(want.status), 12'(rsp_status));
            check_field("byte_count", 12'(want.count),  12'(rsp_byte_count));
            check_field("used_count", want.used,        rsp_used_count);
            check_field("free_count", want.free,        rsp_free_count);
            check_field("last",       12'(want.last),   12'(rsp_last));
            beats_checked++;
            if (want.last) runs_closed++;
         end
      end
   end

   // ---------------------------------------------------------------
   // Watchdog: cycles without any beat on either channel
   // ---------------------------------------------------------------
   int idle_cycles = 0;
   bit timed_out = 1'b0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) timed_out = 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Sequence and end of run
   // ---------------------------------------------------------------
   int fixed_items;
   int random_items;
   int mark;
   int pick;
   int n;
   int len;
   logic [2:0] f;

   initial begin
      // directed: boundaries and corner cases on a small fill
      add_item(FUNC_CLEAR, 0, 8'h00);
      add_item(FUNC_DEQUEUE, 0, 8'h00);
      add_item(FUNC_PEEK, 0, 8'h00);
      add_item(FUNC_DEQUEUE, 5, 8'h00);
      add_item(FUNC_PEEK, 5, 8'h00);
      add_item(FUNC_ENQ_DATA, 0, 8'h5A);
      add_item(FUNC_ENQ_BEGIN, 127, 8'h00);
      add_item(FUNC_ENQ_BEGIN, 0, 8'h00);
      add_item(FUNC_ENQ_DATA, 0, 8'h33);
      add_item(FUNC_ENQ_BEGIN, 3, 8'h00);
      add_item(FUNC_ENQ_DATA, 0, 8'h00);
      add_item(FUNC_ENQ_DATA, 0, 8'hFF);
      add_item(FUNC_ENQ_DATA, 0, 8'hA5);
      add_item(FUNC_ENQ_DATA, 0, 8'h3C);
      add_transfer(4, 2);
      add_transfer(2, 2);
      add_item(FUNC_PEEK, 2, 8'h00);
      add_item(FUNC_PEEK, 10, 8'h00);
      add_item(FUNC_DEQUEUE, 65, 8'h00);
      add_item(FUNC_DEQUEUE, 3, 8'h00);
      for (int u = FUNC_CLEAR + 1; u < 8; u++) add_item(3'(u), 127, 8'hFF);
      fixed_items = req_backlog.size();

      // random: mostly well-formed transfers and reads, some noise
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         mark = req_backlog.size();
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            n = $urandom_range(0, 19);
            n = (n == 0) ? 0 : (n < 3) ? $urandom_range(13, MAX_XFER) : $urandom_range(1, 12);
            add_transfer(n, ($urandom_range(0, 9) == 0) ? $urandom_range(0, n) : n);
            if ($urandom_range(0, 9) == 0) add_item(FUNC_ENQ_DATA, 0, 8'($urandom));
         end else if (pick < 85) begin
            f = ($urandom_range(0, 2) == 0) ? FUNC_PEEK : FUNC_DEQUEUE;
            if ($urandom_range(0, 4) == 0) len = $urandom_range(0, MAX_XFER);
            else len = $urandom_range(0, (plan_used < 16) ? plan_used : 16);
            add_item(f, len, 8'($urandom));
         end else if (pick < 97) begin
            case ($urandom_range(0, 3))
               0: add_item(FUNC_ENQ_DATA, $urandom_range(0, 127), 8'($urandom));
               1: add_item(FUNC_ENQ_BEGIN, $urandom_range(MAX_XFER + 1, 127), 8'($urandom));
               2: add_item(($urandom_range(0, 1) == 0) ? FUNC_PEEK : FUNC_DEQUEUE,
                           $urandom_range(MAX_XFER + 1, 127), 8'($urandom));
               default: add_item(3'($urandom_range(FUNC_CLEAR + 1, 7)),
                                 $urandom_range(0, 127), 8'($urandom));
            endcase
         end else begin
            add_item(FUNC_CLEAR, $urandom_range(0, 127), 8'($urandom));
         end
         random_items += req_backlog.size() - mark;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (!timed_out &&
             !(req_backlog.size() == 0 && !req_valid && awaited_beats.size() == 0))
         @(negedge clock);

      if (timed_out) begin
         $display("Watchdog: no beat for %0d cycles, %0d beats still awaited",
                  IDLE_LIMIT, awaited_beats.size());
         $display("Test completed with failures");
         $finish;
      end else begin
         repeat (DRAIN_CYCLES) @(negedge clock);
         $display("Run covered %0d items (%0d directed, %0d random), incl. empty, short,",
                  items_sent, fixed_items, random_items);
         $display("overlong and stray cases; %0d result beats in %0d runs checked under stalls.",
                  beats_checked, runs_closed);
         if (failures == 0) begin
            $display("Test completed successfully");
         end else begin
            $display("Test completed with failures");
         end
         $finish;
      end
   end

endmodule
